### sv/sod_pkg.sv
// shared types and constants for the sound onset detector
package sod_pkg;

   localparam int SAMPLE_W     = 12;
   localparam int THRESHOLD_W  = 12;
   localparam int COUNT_W      = 16;
   localparam int CSR_DATA_W   = 16;
   localparam int CSR_INDEX_W  = 2;

   localparam int BASELINE_COUNT_DEF = 32;

   localparam logic [THRESHOLD_W-1:0] THRESHOLD_RST = 12'd80;
   localparam logic [COUNT_W-1:0]     COOLDOWN_RST  = 16'd240;
   localparam logic [COUNT_W-1:0]     GRACE_RST     = 16'd600;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COOLDOWN  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRACE     = 2'd2;

   // item opcodes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_REARM  = 1'b1;

   typedef struct packed {
      logic [THRESHOLD_W-1:0] threshold;
      logic [COUNT_W-1:0]     cooldown_samples;
      logic [COUNT_W-1:0]     grace_samples;
   } cfg_type;

   typedef struct packed {
      logic                detected;
      logic                armed;
      logic [SAMPLE_W-1:0] baseline_level;
   } result_type;

endpackage

### sv/sod_csr.sv
// configuration registers of the sound onset detector
module sod_csr
   import sod_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_THRESHOLD: cfg_in.threshold        = csr_wdata[THRESHOLD_W-1:0];
            CSR_COOLDOWN:  cfg_in.cooldown_samples = csr_wdata[COUNT_W-1:0];
            CSR_GRACE:     cfg_in.grace_samples    = csr_wdata[COUNT_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold        <= THRESHOLD_RST;
         cfg_ff.cooldown_samples <= COOLDOWN_RST;
         cfg_ff.grace_samples    <= GRACE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### sv/sod_tracker.sv
// baseline tracking state, grace and cooldown counters, onset decision
module sod_tracker
   import sod_pkg::*;
#(
   parameter int BASELINE_COUNT = BASELINE_COUNT_DEF
)
(
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                step,
   input  logic                op,
   input  logic [SAMPLE_W-1:0] sample,
   output result_type          result
);

   localparam int CNT_W   = $clog2(BASELINE_COUNT);
   localparam int SUM_W   = SAMPLE_W + CNT_W;
   localparam int SHIFT   = SUM_W + CNT_W;
   localparam int RECIP_W = SUM_W + 1;
   localparam int PROD_W  = SUM_W + RECIP_W;
   localparam longint unsigned RECIP =
      ((longint'(1) << SHIFT) + longint'(BASELINE_COUNT) - 1) / longint'(BASELINE_COUNT);
   localparam logic [CNT_W:0] COUNT_LAST = (CNT_W+1)'(BASELINE_COUNT);

   logic [SAMPLE_W-1:0] baseline_ff, baseline_in;
   logic                valid_ff, valid_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [COUNT_W-1:0]  grace_ff, grace_in;
   logic [COUNT_W-1:0]  cooldown_ff, cooldown_in;

   logic [SUM_W-1:0]    sum_add;
   logic [CNT_W:0]      count_add;
   logic [PROD_W-1:0]   mean_prod;
   logic [15:0]         smooth_acc;
   logic [SAMPLE_W-1:0] smooth;
   logic [SAMPLE_W-1:0] dev;
   logic [COUNT_W-1:0]  cooldown_dec;
   logic                det;

   assign sum_add   = sum_ff + SUM_W'(sample);
   assign count_add = {1'b0, count_ff} + (CNT_W+1)'(1);
   // divide by the burst length through a reciprocal multiply
   assign mean_prod = PROD_W'(sum_add) * PROD_W'(RECIP_W'(RECIP));
   // 15*b + s, then floor divide by 16
   assign smooth_acc = {baseline_ff, 4'b0000} - {4'b0000, baseline_ff}
                     + {4'b0000, sample};
   assign smooth = smooth_acc[15:4];
   assign dev    = (sample >= smooth) ? (sample - smooth) : (smooth - sample);
   assign cooldown_dec = (cooldown_ff != '0) ? (cooldown_ff - COUNT_W'(1)) : cooldown_ff;

   always_comb begin
      baseline_in = baseline_ff;
      valid_in    = valid_ff;
      sum_in      = sum_ff;
      count_in    = count_ff;
      grace_in    = grace_ff;
      cooldown_in = cooldown_ff;
      det         = 1'b0;
      if (op == OP_REARM) begin
         baseline_in = '0;
         valid_in    = 1'b0;
         sum_in      = '0;
         count_in    = '0;
         grace_in    = cfg.grace_samples;
      end else begin
         cooldown_in = cooldown_dec;
         if (grace_ff != '0) begin
            grace_in = grace_ff - COUNT_W'(1);
         end else if (!valid_ff) begin
            if (count_add >= COUNT_LAST) begin
               baseline_in = mean_prod[SHIFT +: SAMPLE_W];
               valid_in    = 1'b1;
               sum_in      = '0;
               count_in    = '0;
            end else begin
               sum_in   = sum_add;
               count_in = count_add[CNT_W-1:0];
            end
         end else begin
            baseline_in = smooth;
            if (dev > cfg.threshold && cooldown_dec == '0) begin
               det         = 1'b1;
               cooldown_in = cfg.cooldown_samples;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         baseline_ff <= '0;
         valid_ff    <= 1'b0;
         sum_ff      <= '0;
         count_ff    <= '0;
         grace_ff    <= GRACE_RST;
         cooldown_ff <= '0;
      end else if (step) begin
         baseline_ff <= baseline_in;
         valid_ff    <= valid_in;
         sum_ff      <= sum_in;
         count_ff    <= count_in;
         grace_ff    <= grace_in;
         cooldown_ff <= cooldown_in;
      end
   end

   assign result.detected       = det;
   assign result.armed          = valid_in && (grace_in == '0);
   assign result.baseline_level = baseline_in;

endmodule

### sv/sound_onset_detector_core.sv
// sound onset detector: one result per item
// an item sits in the input register, then its result is registered
// throughput one item per cycle; a held result only stalls once the input register is full
// synchronous active-high reset: baseline cleared, grace reloaded from 600, cooldown clear,
// configuration back to threshold 80, cooldown 240, grace 600
module sound_onset_detector_core
   import sod_pkg::*;
#(
   parameter int BASELINE_COUNT = BASELINE_COUNT_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_op,
   input  logic [SAMPLE_W-1:0]    req_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_detected,
   output logic                   rsp_armed,
   output logic [SAMPLE_W-1:0]    rsp_baseline_level,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type    cfg;
   result_type result;

   logic                in_valid_ff, in_valid_in;
   logic                in_op_ff;
   logic [SAMPLE_W-1:0] in_sample_ff;
   logic                out_valid_ff, out_valid_in;
   result_type          out_ff;
   logic                advance;
   logic                req_xfer;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_xfer  = req_valid && req_ready;

   assign in_valid_in  = req_xfer || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   sod_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sod_tracker #(
      .BASELINE_COUNT (BASELINE_COUNT)
   ) u_tracker (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .step   (advance),
      .op     (in_op_ff),
      .sample (in_sample_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_op_ff     <= req_op;
         in_sample_ff <= req_sample;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_detected       = out_ff.detected;
   assign rsp_armed          = out_ff.armed;
   assign rsp_baseline_level = out_ff.baseline_level;

   // a detection only ever comes from an armed tracker
   a_det_armed : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_detected || rsp_armed))
      else $error("detection reported while not armed");

   // a processed item always shows up as a result in the next cycle
   a_adv_result : assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("processed item produced no result");

   // no transfer may land on a full input register that is not draining
   a_no_overrun : assert property (@(posedge clock) disable iff (reset)
      !(req_xfer && in_valid_ff && !advance))
      else $error("input register overwritten");

   // a stalled result holds its value
   a_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(out_ff)))
      else $error("stalled result changed");

endmodule
